// ===== rtl/stb_pkg.sv =====
// shared types, codes and command decode for the software timer bank
`default_nettype none

package stb_pkg;

  // most fire items reported for one tick
  localparam int unsigned MaxResults = 16;
  // counter width that holds 0 .. MaxResults
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    CMD_INIT    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_DESTROY = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CREATED   = 3'd0,
    ST_STARTED   = 3'd1,
    ST_RUNNING   = 3'd2,
    ST_STOPPED   = 3'd3,
    ST_DESTROYED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_UPD,
    S_HARD,
    S_SOFT,
    S_NONE
  } ctrl_state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic        step;
    logic        upd;
    logic [2:0]  cmd;
    logic [31:0] dly;
    logic [31:0] per;
    logic        hard;
  } ctl_t;

  // what a cell shows to the controller
  typedef struct packed {
    logic    fire_now;
    logic    fire;
    logic    hard;
    status_e status;
  } cell_info_t;

  typedef struct packed {
    logic    acc;
    status_e status;
  } cmd_res_t;

  // status change of a slot command
  function automatic cmd_res_t cmd_result(logic [2:0] cmd, status_e st);
    cmd_res_t r;
    r.acc    = 1'b0;
    r.status = st;
    unique case (cmd)
      CMD_INIT: begin
        r.acc    = 1'b1;
        r.status = ST_CREATED;
      end
      CMD_START: begin
        if (st == ST_CREATED || st == ST_STOPPED) begin
          r.acc    = 1'b1;
          r.status = ST_STARTED;
        end
      end
      CMD_STOP: begin
        if (st == ST_STARTED || st == ST_RUNNING) begin
          r.acc    = 1'b1;
          r.status = ST_STOPPED;
        end
      end
      CMD_DESTROY: begin
        r.acc    = 1'b1;
        r.status = ST_DESTROYED;
      end
      default: begin
        r.acc    = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stb_if.sv =====
// valid/ready channel interfaces for command items and result items
`default_nettype none

interface stb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  slot_index;
  logic [31:0] start_delay;
  logic [31:0] period;
  logic        is_hard;

  modport source (output valid, command, slot_index, start_delay, period, is_hard,
                  input ready);
  modport sink (input valid, command, slot_index, start_delay, period, is_hard,
                output ready);
endinterface

interface stb_out_if;
  logic       valid;
  logic       ready;
  logic       fired;
  logic [3:0] result_slot;
  logic [2:0] slot_state;
  logic       accepted;
  logic       last;

  modport source (output valid, fired, result_slot, slot_state, accepted, last,
                  input ready);
  modport sink (input valid, fired, result_slot, slot_state, accepted, last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/software_timer_bank_unit.sv =====
// Software timer bank top level: a row of slot cells and the scan controller.
// Slot commands: the item is captured, decoded in the command state and its result
// registered once the output is free; the next item is taken only after that.
// Tick: a token walks the cell row for the count update, then for the hard and soft
// reports when a slot fires, else one no-fire report. The walk holds while a report
// waits at the output. One item at a time: no item is taken until the tick ends.
// Reset: every slot destroyed, no token in the row, output empty; no clearing pass.
`default_nettype none

module software_timer_bank_unit #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stb_in_if.sink    in_i,
  stb_out_if.source out_o
);
  import stb_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  ctrl_state_e         state_q, state_d;
  logic [2:0]          cmd_q;
  logic [3:0]          idx_q;
  logic [31:0]         dly_q, per_q;
  logic                hard_q;
  logic [IdxW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]     total_q, total_d, n_q, n_d;
  logic [IdxW-1:0]     addr;
  logic                in_range;
  logic                launch, step, upd, wr;
  logic                out_free, load, hit, want;
  logic [NUM_SLOTS-1:0] tok;
  cell_info_t          info [NUM_SLOTS];
  cell_info_t          sel_info;
  status_e             st_sel;
  cmd_res_t            cres;
  ctl_t                ctl;

  logic       out_valid_q;
  logic       out_fired_q, out_fired_d;
  logic [3:0] out_slot_q, out_slot_d;
  logic [2:0] out_state_q, out_state_d;
  logic       out_acc_q, out_acc_d;
  logic       out_last_q, out_last_d;

  assign addr     = IdxW'(idx_q);
  assign in_range = (32'(idx_q) < 32'(NUM_SLOTS));
  assign st_sel   = in_range ? info[addr].status : ST_DESTROYED;
  assign cres     = cmd_result(cmd_q, st_sel);
  assign sel_info = info[pos_q];
  assign out_free = !out_valid_q || out_o.ready;
  assign want     = (state_q == S_HARD);
  assign hit      = sel_info.fire && (sel_info.hard == want) && (n_q < total_q);

  assign ctl.step = step;
  assign ctl.upd  = upd;
  assign ctl.cmd  = cmd_q;
  assign ctl.dly  = dly_q;
  assign ctl.per  = per_q;
  assign ctl.hard = hard_q;

  // row of slot cells, token handed from cell to cell
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = launch;
    end else begin : g_link
      assign tok_in = tok[i-1];
    end
    stb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .sel_i  (wr && (addr == IdxW'(i))),
      .tok_i  (tok_in),
      .tok_o  (tok[i]),
      .info_o (info[i])
    );
  end

  // controller: next state and result selection
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    total_d     = total_q;
    n_d         = n_q;
    launch      = 1'b0;
    step        = 1'b0;
    upd         = 1'b0;
    wr          = 1'b0;
    load        = 1'b0;
    out_fired_d = out_fired_q;
    out_slot_d  = out_slot_q;
    out_state_d = out_state_q;
    out_acc_d   = out_acc_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.command == CMD_TICK) begin
            launch  = 1'b1;
            step    = 1'b1;
            pos_d   = '0;
            total_d = '0;
            n_d     = '0;
            state_d = S_UPD;
          end else begin
            state_d = S_CMD;
          end
        end
      end
      S_CMD: begin
        if (out_free) begin
          wr          = in_range;
          load        = 1'b1;
          out_fired_d = 1'b0;
          out_slot_d  = idx_q;
          out_state_d = in_range ? cres.status : ST_DESTROYED;
          out_acc_d   = in_range && cres.acc;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_UPD: begin
        step  = 1'b1;
        upd   = 1'b1;
        pos_d = pos_q + IdxW'(1);
        if (sel_info.fire_now && total_q != CntW'(MaxResults)) begin
          total_d = total_q + CntW'(1);
        end
        if (pos_q == LastIdx) begin
          pos_d = '0;
          if (sel_info.fire_now || total_q != '0) begin
            launch  = 1'b1;
            state_d = S_HARD;
          end else begin
            state_d = S_NONE;
          end
        end
      end
      S_HARD, S_SOFT: begin
        step = !hit || out_free;
        if (hit && out_free) begin
          load        = 1'b1;
          out_fired_d = 1'b1;
          out_slot_d  = 4'(pos_q);
          out_state_d = sel_info.status;
          out_acc_d   = 1'b1;
          out_last_d  = ((n_q + CntW'(1)) == total_q);
          n_d         = n_q + CntW'(1);
        end
        if (step) begin
          pos_d = pos_q + IdxW'(1);
          if (pos_q == LastIdx) begin
            pos_d = '0;
            if (state_q == S_HARD) begin
              launch  = 1'b1;
              state_d = S_SOFT;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_NONE: begin
        if (out_free) begin
          load        = 1'b1;
          out_fired_d = 1'b0;
          out_slot_d  = '0;
          out_state_d = ST_CREATED;
          out_acc_d   = 1'b1;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // controller registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      total_q     <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      total_q <= total_d;
      n_q     <= n_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input item and output item payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.command;
      idx_q  <= in_i.slot_index;
      dly_q  <= in_i.start_delay;
      per_q  <= in_i.period;
      hard_q <= in_i.is_hard;
    end
    out_fired_q <= out_fired_d;
    out_slot_q  <= out_slot_d;
    out_state_q <= out_state_d;
    out_acc_q   <= out_acc_d;
    out_last_q  <= out_last_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.fired       = out_fired_q;
  assign out_o.result_slot = out_slot_q;
  assign out_o.slot_state  = out_state_q;
  assign out_o.accepted    = out_acc_q;
  assign out_o.last        = out_last_q;

`ifndef SYNTHESIS
  // at most one token in the cell row
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one scan token in the cell row");

  // no token left in the row once the controller is idle
  a_idle_no_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (tok == '0))
    else $error("scan token present while idle");

  // reported fires never exceed the fire count
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q <= total_q) && (total_q <= CntW'(MaxResults)))
    else $error("fire item count out of bounds");

  // a loaded item is never overwritten before it is taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !load)
    else $error("output item overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/stb_cell.sv =====
// one timer slot cell: holds the slot state and passes the scan token on
`default_nettype none

module stb_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire stb_pkg::ctl_t      ctl_i,
  input  wire logic               sel_i,
  input  wire logic               tok_i,
  output logic                    tok_o,
  output stb_pkg::cell_info_t     info_o
);
  import stb_pkg::*;

  logic        tok_q;
  logic        fire_q, fire_d;
  status_e     status_q, status_d;
  logic [31:0] dly_q, per_q, cnt_q, cnt_d;
  logic        hard_q;
  logic        upd_en;
  logic        fire_now;
  logic        init_wr;
  cmd_res_t    res;
  logic [31:0] init_load, start_load;

  assign res        = cmd_result(ctl_i.cmd, status_q);
  assign upd_en     = ctl_i.step && ctl_i.upd && tok_q;
  assign init_wr    = sel_i && (ctl_i.cmd == CMD_INIT);
  // count already zero or about to reach zero
  assign fire_now   = (status_q == ST_STARTED) && (cnt_q <= 32'd1);
  assign init_load  = (ctl_i.dly != 32'd0) ? ctl_i.dly : ctl_i.per;
  assign start_load = (dly_q != 32'd0) ? dly_q : per_q;

  // command write or tick update of this slot
  always_comb begin
    status_d = status_q;
    fire_d   = fire_q;
    cnt_d    = cnt_q;
    if (sel_i) begin
      status_d = res.status;
      if (ctl_i.cmd == CMD_INIT) begin
        cnt_d = init_load;
      end else if (ctl_i.cmd == CMD_START && res.acc) begin
        cnt_d = start_load;
      end
    end else if (upd_en) begin
      fire_d = fire_now;
      if (status_q == ST_STARTED) begin
        if (fire_now) begin
          if (per_q != 32'd0) begin
            cnt_d = per_q;
          end else begin
            cnt_d    = '0;
            status_d = ST_STOPPED;
          end
        end else begin
          cnt_d = cnt_q - 32'd1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      fire_q   <= 1'b0;
      status_q <= ST_DESTROYED;
    end else begin
      if (ctl_i.step) begin
        tok_q <= tok_i;
      end
      fire_q   <= fire_d;
      status_q <= status_d;
    end
  end

  // slot payload, always written by init before use
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (init_wr) begin
      dly_q  <= ctl_i.dly;
      per_q  <= ctl_i.per;
      hard_q <= ctl_i.hard;
    end
  end

  assign tok_o           = tok_q;
  assign info_o.fire_now = fire_now;
  assign info_o.fire     = fire_q;
  assign info_o.hard     = hard_q;
  assign info_o.status   = status_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the software timer bank: random and directed command items checked against a mirror
`timescale 1ns / 1ps

module tb_top;
  import stb_pkg::*;

  localparam int unsigned SlotCount    = 16;
  localparam int unsigned ItemGoal     = 480;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned IdlePercent  = 8;
  localparam int unsigned ErrorsShown  = 10;
  // sender runs without gaps over this span of items
  localparam int unsigned BusyFirst    = 200;
  localparam int unsigned BusyLast     = 320;
  // receiver stall window and gap-free window, in cycles after reset
  localparam int unsigned HoldFrom     = 1500;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned OpenFrom     = 5000;
  localparam int unsigned OpenTo       = 8000;
  // command codes the block leaves undecoded
  localparam logic [2:0]  CmdSpareLo   = 3'd5;
  localparam logic [2:0]  CmdSpareHi   = 3'd7;

  typedef struct packed {
    logic       fired;
    logic [3:0] slot;
    logic [2:0] state;
    logic       accepted;
    logic       last;
  } report_t;

  // mirror of the slot bank and the queue of reports still to come
  class timer_bank_mirror;
    logic [31:0] delay_q  [SlotCount];
    logic [31:0] period_q [SlotCount];
    logic [31:0] count_q  [SlotCount];
    status_e     status_q [SlotCount];
    logic        hard_q   [SlotCount];
    report_t     awaited[$];
    int unsigned fault_count;

    function new();
      for (int i = 0; i < SlotCount; i++) begin
        delay_q[i]  = '0;
        period_q[i] = '0;
        count_q[i]  = '0;
        status_q[i] = ST_DESTROYED;
        hard_q[i]   = 1'b0;
      end
      fault_count = 0;
    endfunction

    function void push_report(logic fired, logic [3:0] slot, logic [2:0] state,
                              logic accepted, logic last);
      report_t r;
      r.fired    = fired;
      r.slot     = slot;
      r.state    = state;
      r.accepted = accepted;
      r.last     = last;
      awaited.push_back(r);
    endfunction

    // advance the mirror by one accepted item; returns 1 when the item took effect
    function bit apply_item(logic [2:0] op, logic [3:0] slot, logic [31:0] dly,
                            logic [31:0] per, logic hard);
      logic    fires [SlotCount];
      int      total;
      int      n;
      bit      took;
      status_e prior;
      total = 0;
      n     = 0;
      took  = 1'b0;
      if (op == CMD_TICK) begin
        // count down every started slot, reload or stop the ones that expire
        for (int i = 0; i < SlotCount; i++) begin
          fires[i] = 1'b0;
          if (status_q[i] == ST_STARTED) begin
            if (count_q[i] == 0) begin
              fires[i] = 1'b1;
            end else begin
              count_q[i] = count_q[i] - 1;
              fires[i]   = (count_q[i] == 0);
            end
            if (fires[i]) begin
              total++;
              if (period_q[i] != 0) count_q[i] = period_q[i];
              else status_q[i] = ST_STOPPED;
            end
          end
        end
        if (total == 0) begin
          push_report(1'b0, 4'd0, ST_CREATED, 1'b1, 1'b1);
        end else begin
          // hard slots first, then soft, each in slot order
          for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < SlotCount; i++) begin
              if (fires[i] && hard_q[i] == (pass == 0)) begin
                n++;
                push_report(1'b1, 4'(i), status_q[i], 1'b1, n == total);
              end
            end
          end
        end
        return 1'b1;
      end
      prior = status_q[slot];
      case (op)
        CMD_INIT: begin
          delay_q[slot]  = dly;
          period_q[slot] = per;
          hard_q[slot]   = hard;
          count_q[slot]  = (dly != 0) ? dly : per;
          status_q[slot] = ST_CREATED;
          took           = 1'b1;
        end
        CMD_START: begin
          if (prior == ST_CREATED || prior == ST_STOPPED) begin
            count_q[slot]  = (delay_q[slot] != 0) ? delay_q[slot] : period_q[slot];
            status_q[slot] = ST_STARTED;
            took           = 1'b1;
          end
        end
        CMD_STOP: begin
          if (prior == ST_STARTED || prior == ST_RUNNING) begin
            status_q[slot] = ST_STOPPED;
            took           = 1'b1;
          end
        end
        CMD_DESTROY: begin
          status_q[slot] = ST_DESTROYED;
          took           = 1'b1;
        end
        default: begin
          took = 1'b0;
        end
      endcase
      push_report(1'b0, slot, status_q[slot], took, 1'b1);
      return took;
    endfunction

    function void note_fault(string msg);
      fault_count++;
      if (fault_count <= ErrorsShown) $display("mismatch: %s", msg);
    endfunction

    // check one report taken from the output against the oldest one awaited
    function void compare_result(report_t got);
      report_t want;
      if (awaited.size() == 0) begin
        note_fault($sformatf("report with none awaited: fired %0b slot %0d state %0d",
                             got.fired, got.slot, got.state));
        return;
      end
      want = awaited.pop_front();
      if (got.fired !== want.fired || got.slot !== want.slot || got.state !== want.state ||
          got.accepted !== want.accepted || got.last !== want.last) begin
        note_fault($sformatf({"want/got fired %0b/%0b slot %0d/%0d state %0d/%0d ",
                              "accepted %0b/%0b last %0b/%0b"},
                             want.fired, got.fired, want.slot, got.slot, want.state,
                             got.state, want.accepted, got.accepted, want.last, got.last));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  stb_in_if  cmd_if ();
  stb_out_if rpt_if ();

  software_timer_bank_unit #(
    .NUM_SLOTS(SlotCount)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rpt_if)
  );

  timer_bank_mirror mirror = new();
  int unsigned      sent_items;
  int unsigned      useful_items;
  int unsigned      cycle_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("** software_timer_bank_unit: FAILED **");
        $finish;
      end
    end
  end

  // offer one command item, with random gaps before it, and wait until it is taken
  task automatic put_item(input logic [2:0] op, input logic [3:0] slot,
                          input logic [31:0] dly, input logic [31:0] per, input logic hard);
    while (!(sent_items >= BusyFirst && sent_items < BusyLast) &&
           $urandom_range(0, 99) < IdlePercent) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= op;
    cmd_if.slot_index  <= slot;
    cmd_if.start_delay <= dly;
    cmd_if.period      <= per;
    cmd_if.is_hard     <= hard;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    if (mirror.apply_item(op, slot, dly, per, hard)) useful_items++;
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic tick_item();
    put_item(CMD_TICK, 4'($urandom_range(0, 15)), $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // mostly short counts so slots expire often, now and then a full-range value
  function automatic logic [31:0] pick_count();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 4);
  endfunction

  // result side: ready with random gaps, one long hold and one gap-free span
  initial begin : report_sink
    int unsigned cyc;
    cyc          = 0;
    rpt_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= HoldFrom && cyc < HoldFrom + HoldCycles) rpt_if.ready <= 1'b0;
      else if (cyc >= OpenFrom && cyc < OpenTo) rpt_if.ready <= 1'b1;
      else rpt_if.ready <= ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // take reports at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && rpt_if.valid && rpt_if.ready) begin
      mirror.compare_result({rpt_if.fired, rpt_if.result_slot, rpt_if.slot_state,
                             rpt_if.accepted, rpt_if.last});
    end
  end

  // reset, directed items, random items, drain
  initial begin
    int unsigned kind;
    int unsigned slot;
    sent_items         = 0;
    useful_items       = 0;
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = CMD_INIT;
    cmd_if.slot_index  = '0;
    cmd_if.start_delay = '0;
    cmd_if.period      = '0;
    cmd_if.is_hard     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // commands on destroyed slots, undecoded codes, tick with nothing running
    put_item(CMD_TICK, 4'd0, 32'd0, 32'd0, 1'b0);
    put_item(CMD_START, 4'd0, 32'd0, 32'd0, 1'b0);
    put_item(CMD_STOP, 4'd0, 32'd0, 32'd0, 1'b0);
    put_item(CmdSpareLo, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    put_item(CmdSpareHi, 4'd15, 32'd0, 32'd0, 1'b0);
    // zero delay and zero period: count already zero, fires on the first tick, one-shot
    put_item(CMD_INIT, 4'd0, 32'd0, 32'd0, 1'b1);
    put_item(CMD_START, 4'd0, 32'd0, 32'd0, 1'b0);
    put_item(CMD_TICK, 4'd0, 32'd0, 32'd0, 1'b0);
    // periodic soft slot, double start refused
    put_item(CMD_INIT, 4'd15, 32'd2, 32'd3, 1'b0);
    put_item(CMD_START, 4'd15, 32'd0, 32'd0, 1'b0);
    put_item(CMD_START, 4'd15, 32'd0, 32'd0, 1'b0);
    put_item(CMD_TICK, 4'd0, 32'd0, 32'd0, 1'b0);
    put_item(CMD_TICK, 4'd0, 32'd0, 32'd0, 1'b0);
    // zero delay falls back to the period; hard and soft fire together
    put_item(CMD_INIT, 4'd1, 32'd0, 32'd1, 1'b1);
    put_item(CMD_START, 4'd1, 32'd0, 32'd0, 1'b0);
    put_item(CMD_INIT, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    put_item(CMD_STOP, 4'd2, 32'd0, 32'd0, 1'b0);
    put_item(CMD_START, 4'd2, 32'd0, 32'd0, 1'b0);
    put_item(CMD_STOP, 4'd2, 32'd0, 32'd0, 1'b0);
    put_item(CMD_START, 4'd2, 32'd0, 32'd0, 1'b0);
    // init over a started slot takes it out of counting
    put_item(CMD_INIT, 4'd2, 32'd1, 32'd0, 1'b0);
    put_item(CMD_START, 4'd2, 32'd0, 32'd0, 1'b0);
    put_item(CMD_TICK, 4'd0, 32'd0, 32'd0, 1'b0);
    put_item(CMD_DESTROY, 4'd15, 32'd0, 32'd0, 1'b0);
    put_item(CMD_DESTROY, 4'd15, 32'd0, 32'd0, 1'b0);
    put_item(CMD_TICK, 4'd0, 32'd0, 32'd0, 1'b0);

    // random sequences: mostly init/start/tick with random content, some noise
    while (useful_items < ItemGoal) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        // every slot gets a short count; those at one or zero expire on the same tick
        for (int i = 0; i < SlotCount; i++) begin
          put_item(CMD_INIT, 4'(i), 32'($urandom_range(0, 1)), 32'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
        end
        for (int i = 0; i < SlotCount; i++) put_item(CMD_START, 4'(i), $urandom, $urandom, 1'b0);
        tick_item();
      end else if (kind < 55) begin
        slot = $urandom_range(0, SlotCount - 1);
        put_item(CMD_INIT, 4'(slot), pick_count(), pick_count(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) != 0) put_item(CMD_START, 4'(slot), $urandom, $urandom, 1'b0);
        repeat ($urandom_range(0, 3)) tick_item();
        if ($urandom_range(0, 4) == 0) put_item(CMD_STOP, 4'(slot), $urandom, $urandom, 1'b0);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 5)) tick_item();
      end else begin
        put_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), $urandom, $urandom,
                 1'($urandom_range(0, 1)));
      end
    end
    cmd_if.valid <= 1'b0;

    // drain, then let a full tick scan go by for stray reports
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (3 * SlotCount + 8) @(posedge clk_i);
    if (mirror.fault_count == 0 && mirror.awaited.size() == 0) begin
      $display("** software_timer_bank_unit: PASSED **");
    end else begin
      $display("** software_timer_bank_unit: FAILED **");
    end
    $finish;
  end

endmodule
